### hdl/m2h_pkg.sv
`timescale 1ns / 1ps

package m2h_pkg;

  // Hash constants
  localparam logic [31:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned WordShift = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  // Queue between the front and the back end
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_TAIL,
    KIND_FULL
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        first;
    logic        last;
    logic [31:0] word;
    logic [31:0] start;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_TAIL,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

### hdl/m2h_in_if.sv
`timescale 1ns / 1ps

interface m2h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  bytes_valid;
  logic        is_last;
  logic [31:0] message_length;

  modport source (output valid, output data_word, output bytes_valid,
                  output is_last, output message_length, input ready);
  modport sink   (input valid, input data_word, input bytes_valid,
                  input is_last, input message_length, output ready);
endinterface

### hdl/m2h_out_if.sv
`timescale 1ns / 1ps

interface m2h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

### hdl/m2h_fifo.sv
`timescale 1ns / 1ps

module m2h_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  m2h_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output m2h_pkg::item_t pop_data_o,
  output logic           empty_o
);
  import m2h_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/m2h_front.sv
`timescale 1ns / 1ps

module m2h_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i,
  m2h_in_if.sink         in_i,
  output logic           push_o,
  output m2h_pkg::item_t push_data_o,
  input  logic           full_i
);
  import m2h_pkg::*;

  logic [31:0] seed_q;
  logic        in_msg_q, in_msg_d;
  logic [31:0] mask;
  kind_e       kind;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_data_i;
    end
  end

  // classify by byte count; oversized counts act as a full word
  always_comb begin
    unique case (in_i.bytes_valid) inside
      3'd0: begin
        kind = KIND_EMPTY;
        mask = 32'h0000_0000;
      end
      3'd1: begin
        kind = KIND_TAIL;
        mask = 32'h0000_00ff;
      end
      3'd2: begin
        kind = KIND_TAIL;
        mask = 32'h0000_ffff;
      end
      3'd3: begin
        kind = KIND_TAIL;
        mask = 32'h00ff_ffff;
      end
      [3'd4:3'd7]: begin
        kind = KIND_FULL;
        mask = 32'hffff_ffff;
      end
      default: begin
        kind = KIND_FULL;
        mask = 32'hffff_ffff;
      end
    endcase
  end

  always_comb begin
    push_data_o.kind  = kind;
    push_data_o.first = !in_msg_q;
    push_data_o.last  = in_i.is_last;
    push_data_o.word  = in_i.data_word & mask;
    push_data_o.start = seed_q ^ in_i.message_length;
  end

  // message tracking: next transfer after a last one starts a new message
  assign in_msg_d = push_o ? !in_i.is_last : in_msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
    end
  end

endmodule

### hdl/m2h_back.sv
`timescale 1ns / 1ps

module m2h_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  m2h_pkg::item_t pop_data_i,
  input  logic           empty_i,
  output logic           pop_o,
  m2h_out_if.source      out_o
);
  import m2h_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] w_q, w_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q;
  logic        load_out;
  logic        out_free;
  logic [31:0] mul_a;
  logic [31:0] prod;

  assign out_free = !out_valid_q || out_o.ready;

  // shared constant multiplier, low 32 bits
  assign prod = mul_a * MixMul;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (pop_data_i.kind)
            KIND_FULL:  state_d = ST_K1;
            KIND_TAIL:  state_d = ST_TAIL;
            KIND_EMPTY: state_d = pop_data_i.last ? ST_FIN : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_K1:   state_d = ST_K2;
      ST_K2:   state_d = ST_HMIX;
      ST_HMIX: state_d = last_q ? ST_FIN : ST_IDLE;
      ST_TAIL: state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    mul_a    = h_q;
    h_d      = h_q;
    k_d      = k_q;
    w_d      = w_q;
    last_d   = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          h_d    = pop_data_i.first ? pop_data_i.start : h_q;
          w_d    = pop_data_i.word;
          last_d = pop_data_i.last;
        end
      end
      ST_K1: begin
        mul_a = w_q;
        k_d   = prod;
      end
      ST_K2: begin
        mul_a = k_q ^ (k_q >> WordShift);
        k_d   = prod;
      end
      ST_HMIX: begin
        mul_a = h_q;
        h_d   = prod ^ k_q;
      end
      ST_TAIL: begin
        mul_a = h_q ^ w_q;
        h_d   = prod;
      end
      ST_FIN: begin
        mul_a = h_q ^ (h_q >> FinShiftA);
        h_d   = prod;
      end
      ST_OUT: begin
        load_out = out_free;
      end
      default: begin
        mul_a = h_q;
      end
    endcase
  end

  // output register
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    k_q <= k_d;
    w_q <= w_d;
    if (load_out) begin
      out_hash_q <= h_q ^ (h_q >> FinShiftB);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

endmodule

### hdl/murmur2_hash32.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                                            | Handshake
// in_i    | in  | data_word, bytes_valid, is_last, message_length    | valid/ready
// out_o   | out | hash_value                                         | valid/ready
// cfg     | in  | cfg_data_i (hash_seed)                             | cfg_we_i
//
// Back end states per item: full word IDLE, K1, K2, HMIX; tail IDLE, TAIL; empty
// IDLE only; a last item adds FIN and OUT plus any wait on out_o. All mixing steps
// share one 32x32 constant multiplier in the back end.
// A 2-entry queue lets the front take items while the back end is busy.
// rst_ni clears the seed to 0, the queue, the sequencer and the result valid.

module murmur2_hash32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  m2h_in_if.sink      in_i,
  m2h_out_if.source   out_o
);
  import m2h_pkg::*;

  item_t push_data;
  item_t pop_data;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  m2h_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  m2h_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  m2h_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

### hdl/m2h_checker.sv
`timescale 1ns / 1ps

module m2h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_hash_i
);

  logic [3:0] pend_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i && in_last_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // messages closed at the input but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hash_i))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0)
    else $error("result without a finished message");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && pend_q == 4'd0 |=> !out_valid_i)
    else $error("result appeared too early");

endmodule

bind murmur2_hash32 m2h_checker u_m2h_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.is_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hash_i  (out_o.hash_value)
);
